[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// spq_pkg: types and codes shared by the stable priority queue
// no dependencies
package spq_pkg;

    localparam int TagW = 16;
    localparam int UrgW = 16;
    localparam int OccW = 7;

    typedef enum logic {
        REQ_ADMIT = 1'b0,
        REQ_SERVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_ADMITTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic            valid;
        logic [TagW-1:0] tag;
        logic [UrgW-1:0] urgency;
    } entry_t;

    // broadcast to every cell in the row
    typedef struct packed {
        cell_op_t        op;
        logic [TagW-1:0] tag;
        logic [UrgW-1:0] urgency;
    } cell_cmd_t;

endpackage

[rtl/core/spq_req_if.sv]
`timescale 1ns / 1ps
// spq_req_if: request channel of the priority queue
// depends on nothing
interface spq_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] tag;
    logic [15:0] urgency;

    modport source (output valid, output req_type, output tag, output urgency, input ready);
    modport sink (input valid, input req_type, input tag, input urgency, output ready);
endinterface

[rtl/core/spq_rsp_if.sv]
`timescale 1ns / 1ps
// spq_rsp_if: response channel of the priority queue
// depends on nothing
interface spq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] served_tag;
    logic [6:0]  occupancy;

    modport source (output valid, output status, output served_tag, output occupancy,
                    input ready);
    modport sink (input valid, input status, input served_tag, input occupancy,
                  output ready);
endinterface

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted systolic array
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    left,
    input  logic      left_keep,
    input  entry_t    right,
    output entry_t    entry,
    output logic      keep
);

    logic            valid_reg;
    logic            valid_next;
    logic [TagW-1:0] tag_reg;
    logic [TagW-1:0] tag_next;
    logic [UrgW-1:0] urg_reg;
    logic [UrgW-1:0] urg_next;

    // equal urgency stays ahead of the newcomer, so ties serve in admission order
    assign keep = valid_reg && (urg_reg >= cmd.urgency);

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        urg_next   = urg_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        tag_next   = cmd.tag;
                        urg_next   = cmd.urgency;
                    end
                    else
                    begin
                        valid_next = left.valid;
                        tag_next   = left.tag;
                        urg_next   = left.urgency;
                    end
                end
            end
            CELL_REMOVE:
            begin
                valid_next = right.valid;
                tag_next   = right.tag;
                urg_next   = right.urgency;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        urg_reg <= urg_next;
    end

    assign entry = '{valid: valid_reg, tag: tag_reg, urgency: urg_reg};

endmodule

[rtl/core/stable_priority_queue.sv]
`timescale 1ns / 1ps
// stable_priority_queue: sorted row of QUEUE_DEPTH cells, head cell is served next
// the response is registered; one request per cycle while the response channel is not
// stalled, set by the urgency compare broadcast to all cells in parallel
// reset clears every cell's valid bit, the entry count and the response valid bit
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    entry_t    cells [QUEUE_DEPTH];
    logic      keeps [QUEUE_DEPTH];
    cell_cmd_t cmd;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              rsp_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [TagW-1:0]   served_tag_reg;
    logic [TagW-1:0]   served_tag_next;
    logic [CntW+OccW-1:0] count_ext;

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign full      = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        cmd.op          = CELL_HOLD;
        cmd.tag         = req.tag;
        cmd.urgency     = req.urgency;
        count_next      = count_reg;
        status_next     = status_reg;
        served_tag_next = served_tag_reg;
        if (accept)
        begin
            unique case (req_type_t'(req.req_type))
                REQ_ADMIT:
                begin
                    served_tag_next = '0;
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op      = CELL_INSERT;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_ADMITTED;
                    end
                end
                REQ_SERVE:
                begin
                    if (empty)
                    begin
                        status_next     = ST_EMPTY;
                        served_tag_next = '0;
                    end
                    else
                    begin
                        cmd.op          = CELL_REMOVE;
                        count_next      = count_reg - 1'b1;
                        status_next     = ST_SERVED;
                        served_tag_next = cells[0].tag;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_keep;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_keep  = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cells[i-1];
            assign left_keep  = keeps[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = '0;
        end
        else
        begin : g_inner
            assign right_entry = cells[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left      (left_entry),
            .left_keep (left_keep),
            .right     (right_entry),
            .entry     (cells[i]),
            .keep      (keeps[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        served_tag_reg <= served_tag_next;
    end

    // occupancy shows the count modulo 128
    assign count_ext      = {{OccW{1'b0}}, count_reg};
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.served_tag = served_tag_reg;
    assign rsp.occupancy  = count_ext[OccW-1:0];

endmodule
